// File: sv/mpem_pkg.sv
// Shared types and constants of the multi-pattern exact matcher.
`timescale 1ns / 1ps
package mpem_pkg;
   localparam int MaxPatterns   = 32;
   localparam int MaxPatternLen = 32;
   localparam int PatIdxW  = $clog2(MaxPatterns);
   localparam int PatCntW  = $clog2(MaxPatterns + 1);
   localparam int PosW     = $clog2(MaxPatternLen);
   localparam int LenW     = $clog2(MaxPatternLen + 1);
   localparam int StoreDepth = MaxPatterns * MaxPatternLen;
   localparam int StoreAw  = $clog2(StoreDepth);

   localparam logic [1:0] ActAppend = 2'd0;
   localparam logic [1:0] ActClose  = 2'd1;
   localparam logic [1:0] ActText   = 2'd2;

   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5a;
   localparam logic [7:0] CaseDelta  = 8'h20;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_EMIT  = 5'b00100,
      ST_SUMM  = 5'b01000,
      ST_WAIT  = 5'b10000
   } ctl_state_type;

   typedef struct packed {
      logic       store_byte;
      logic       close_pat;
      logic       shift_text;
      logic       scan_step;
      logic       take_match;
      logic       load_summary;
      logic       end_text;
   } dp_cmd_type;

   typedef struct packed {
      logic       scan_done;
      logic       hit;
      logic       more_hits;
   } dp_status_type;

   function automatic logic [7:0] fold(input logic en, input logic [7:0] c);
      if (en && c >= CharUpperA && c <= CharUpperZ) return c + CaseDelta;
      return c;
   endfunction
endpackage

// File: sv/mpem_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module mpem_ram #(
   parameter int Width = 8,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// File: sv/mpem_datapath.sv
// Pattern store, text window, per-pattern match cells and result register.
`timescale 1ns / 1ps
module mpem_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fold_case,
   input  logic [7:0]               data_byte,
   input  mpem_pkg::dp_cmd_type     cmd,
   output mpem_pkg::dp_status_type  status,
   output logic [5:0]               pattern_number,
   output logic [31:0]              match_offset,
   output logic [31:0]              match_total,
   output logic                     is_summary
);
   localparam int N = mpem_pkg::MaxPatterns;
   localparam int L = mpem_pkg::MaxPatternLen;

   logic [mpem_pkg::PatCntW-1:0] count_ff, count_in;
   logic [mpem_pkg::LenW-1:0]    cursor_ff, cursor_in;
   logic [mpem_pkg::LenW-1:0]    len_ff [N];
   logic [7:0]                   win_ff [L];
   logic [mpem_pkg::LenW-1:0]    fill_ff;
   logic [31:0]                  pos_ff, total_ff;
   logic [N-1:0]                 alive_ff;
   logic [N-1:0]                 hits_ff;
   logic [mpem_pkg::PosW-1:0]    j_ff;
   logic                         jv_ff;
   logic [5:0]                   num_ff;
   logic [31:0]                  off_ff, tot_out_ff;
   logic                         summ_ff;

   // Pattern byte store: one byte of every pattern is read per scan step.
   logic [7:0] rd_byte [N];
   logic       wr_en;
   assign wr_en = cmd.store_byte && count_ff < mpem_pkg::PatCntW'(N) &&
                  cursor_ff < mpem_pkg::LenW'(L);

   for (genvar p = 0; p < N; p++) begin : g_bank
      logic we;
      assign we = wr_en && count_ff[mpem_pkg::PatIdxW-1:0] == mpem_pkg::PatIdxW'(p);
      mpem_ram #(.Width(8), .Depth(L)) u_ram (
         .clock  (clock),
         .wr_en  (we),
         .wr_addr(mpem_pkg::PosW'(cursor_ff)),
         .wr_data(data_byte),
         .rd_addr(j_ff),
         .rd_data(rd_byte[p])
      );
   end

   always_comb begin
      count_in  = count_ff;
      cursor_in = cursor_ff;
      if (wr_en) cursor_in = cursor_ff + 1'b1;
      if (cmd.close_pat) begin
         if (count_ff < mpem_pkg::PatCntW'(N) && cursor_ff != '0)
            count_in = count_ff + 1'b1;
         cursor_in = '0;
      end
   end

   // Highest hit pattern index.
   logic [mpem_pkg::PatIdxW-1:0] top_idx;
   always_comb begin
      top_idx = '0;
      for (int p = 0; p < N; p++) if (hits_ff[p]) top_idx = mpem_pkg::PatIdxW'(p);
   end

   logic [N-1:0] hits_clr;
   always_comb begin
      hits_clr = hits_ff;
      hits_clr[top_idx] = 1'b0;
   end

   assign status.scan_done = !jv_ff && j_ff == '0;
   assign status.hit       = |hits_ff;
   assign status.more_hits = |hits_clr;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cursor_ff <= '0;
         fill_ff   <= '0;
         pos_ff    <= '0;
         total_ff  <= '0;
         alive_ff  <= '0;
         hits_ff   <= '0;
         j_ff      <= '0;
         jv_ff     <= 1'b0;
         for (int p = 0; p < N; p++) len_ff[p] <= '0;
         for (int k = 0; k < L; k++) win_ff[k] <= '0;
      end else begin
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         if (cmd.close_pat && count_ff < mpem_pkg::PatCntW'(N) && cursor_ff != '0)
            len_ff[count_ff[mpem_pkg::PatIdxW-1:0]] <= cursor_ff;
         if (cmd.shift_text) begin
            for (int k = L - 1; k > 0; k--) win_ff[k] <= win_ff[k-1];
            win_ff[0] <= data_byte;
            if (fill_ff < mpem_pkg::LenW'(L)) fill_ff <= fill_ff + 1'b1;
            for (int p = 0; p < N; p++)
               alive_ff[p] <= mpem_pkg::PatCntW'(p) < count_ff && len_ff[p] != '0 &&
                  len_ff[p] <= (fill_ff < mpem_pkg::LenW'(L) ? fill_ff + 1'b1 : fill_ff);
            j_ff  <= '0;
            jv_ff <= 1'b1;
         end
         if (cmd.scan_step) begin
            // rd_byte holds byte j-1 of each pattern; compare with its window byte
            if (j_ff != '0 || !jv_ff) begin
               for (int p = 0; p < N; p++) begin
                  logic [mpem_pkg::PosW-1:0] jj;
                  logic [mpem_pkg::LenW-1:0] wi;
                  jj = jv_ff ? j_ff - 1'b1 : mpem_pkg::PosW'(L - 1);
                  wi = len_ff[p] - 1'b1 - mpem_pkg::LenW'(jj);
                  if (mpem_pkg::LenW'(jj) < len_ff[p] &&
                      mpem_pkg::fold(fold_case, rd_byte[p]) !=
                      mpem_pkg::fold(fold_case, win_ff[mpem_pkg::PosW'(wi)]))
                     alive_ff[p] <= 1'b0;
               end
            end
            if (jv_ff) begin
               if (j_ff == mpem_pkg::PosW'(L - 1)) jv_ff <= 1'b0;
               else j_ff <= j_ff + 1'b1;
            end else j_ff <= '0;
         end
         if (cmd.scan_step && status.scan_done) hits_ff <= alive_ff;
         if (cmd.take_match) begin
            hits_ff <= hits_clr;
            if (total_ff != '1) total_ff <= total_ff + 1'b1;
         end
         if (cmd.end_text) begin
            fill_ff  <= '0;
            pos_ff   <= '0;
            total_ff <= '0;
            for (int k = 0; k < L; k++) win_ff[k] <= '0;
         end else if (cmd.scan_step && status.scan_done) begin
            pos_ff <= pos_ff + 1'b1;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.take_match) begin
         num_ff     <= 6'(top_idx) + 6'd1;
         off_ff     <= pos_ff - 32'(len_ff[top_idx]);
         tot_out_ff <= '0;
         summ_ff    <= 1'b0;
      end else if (cmd.load_summary) begin
         num_ff     <= '0;
         off_ff     <= '0;
         tot_out_ff <= total_ff;
         summ_ff    <= 1'b1;
      end
   end
   assign pattern_number = num_ff;
   assign match_offset   = off_ff;
   assign match_total    = tot_out_ff;
   assign is_summary     = summ_ff;
endmodule

// File: sv/mpem_ctrl.sv
// Controller state machine: handshakes, scan sequencing and result emission.
`timescale 1ns / 1ps
module mpem_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [1:0]              action,
   input  logic                    text_last,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic                    rsp_tlast,
   output mpem_pkg::dp_cmd_type    cmd,
   input  mpem_pkg::dp_status_type status
);
   mpem_pkg::ctl_state_type state_ff, state_in;
   logic last_ff, last_in;
   logic vld_ff, vld_in, tl_ff, tl_in;
   logic fire, out_free;

   assign out_free   = !vld_ff || rsp_tready;
   assign req_tready = state_ff == mpem_pkg::ST_IDLE;
   assign fire       = req_tvalid && req_tready;
   assign rsp_tvalid = vld_ff;
   assign rsp_tlast  = tl_ff;

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      vld_in   = vld_ff && !rsp_tready;
      tl_in    = tl_ff;
      cmd      = '0;
      case (state_ff)
         mpem_pkg::ST_IDLE: begin
            if (fire) begin
               case (action)
                  mpem_pkg::ActAppend: cmd.store_byte = 1'b1;
                  mpem_pkg::ActClose:  cmd.close_pat  = 1'b1;
                  mpem_pkg::ActText: begin
                     cmd.shift_text = 1'b1;
                     last_in  = text_last;
                     state_in = mpem_pkg::ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         mpem_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) state_in = mpem_pkg::ST_EMIT;
         end
         mpem_pkg::ST_EMIT: begin
            if (!status.hit) begin
               state_in = last_ff ? mpem_pkg::ST_SUMM : mpem_pkg::ST_IDLE;
            end else if (out_free) begin
               cmd.take_match = 1'b1;
               vld_in = 1'b1;
               tl_in  = !status.more_hits && !last_ff;
            end
         end
         mpem_pkg::ST_SUMM: begin
            if (out_free) begin
               cmd.load_summary = 1'b1;
               vld_in   = 1'b1;
               tl_in    = 1'b1;
               state_in = mpem_pkg::ST_WAIT;
            end
         end
         mpem_pkg::ST_WAIT: begin
            cmd.end_text = 1'b1;
            state_in = mpem_pkg::ST_IDLE;
         end
         default: state_in = mpem_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpem_pkg::ST_IDLE;
         last_ff  <= 1'b0;
         vld_ff   <= 1'b0;
         tl_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
         vld_ff   <= vld_in;
         tl_ff    <= tl_in;
      end
   end
endmodule

// File: sv/multi_pattern_exact_matcher_core.sv
// Top level of the multi-pattern exact matcher.
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata data_byte, tuser action, tlast text_last
//  rsp     | out | rsp_tvalid/tready    | tdata {total,offset,number}, tuser is_summary, tlast
//  csr     | in  | csr_valid/csr_ready  | csr_data fold_case
// A pattern byte or close is taken in the idle state. A text byte is accepted, then
// scanned in steps over the pattern RAM banks, then checked in the emit state, which
// sends one result per match; the last text byte adds a summary word. Reset is synchronous;
// no clearing pass. A stalled result holds the emit sequence; input is taken only when idle.
`timescale 1ns / 1ps
module multi_pattern_exact_matcher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // data_byte[7:0]
   input  logic [1:0]  req_tuser,  // action[1:0]
   input  logic        req_tlast,  // text_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // pattern_number[5:0], match_offset[37:6],
                                   // match_total[69:38], zero fill
   output logic        rsp_tuser,  // is_summary
   output logic        rsp_tlast,  // last_result
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data    // fold_case
);
   logic fold_ff;
   mpem_pkg::dp_cmd_type    cmd;
   mpem_pkg::dp_status_type status;
   logic [5:0]  num;
   logic [31:0] off, tot;
   logic        summ;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) fold_ff <= 1'b0;
      else if (csr_valid) fold_ff <= csr_data;
   end

   mpem_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .action(req_tuser), .text_last(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tlast(rsp_tlast),
      .cmd(cmd), .status(status)
   );

   mpem_datapath u_dp (
      .clock(clock), .reset(reset), .fold_case(fold_ff),
      .data_byte(req_tdata), .cmd(cmd), .status(status),
      .pattern_number(num), .match_offset(off), .match_total(tot), .is_summary(summ)
   );

   assign rsp_tdata = {2'b00, tot, off, num};
   assign rsp_tuser = summ;
endmodule

// File: tb/mpem_checker.sv
// Checker of the multi-pattern exact matcher: predicts results from accepted words and compares.
`timescale 1ns / 1ps
module mpem_checker
   import mpem_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_data,
   output int          fail_count,
   output int          pending_matches,
   output int          match_words_seen,
   output int          summary_words_seen
);
   typedef struct packed {
      logic [5:0]  number;
      logic [31:0] offset;
      logic [31:0] total;
      logic        summary;
      logic        last;
   } match_word_t;

   match_word_t match_queue[$];

   logic        fold_en;
   logic [7:0]  pat_mem [MaxPatterns][MaxPatternLen];
   int unsigned pat_len [MaxPatterns];
   int unsigned stored_pats;
   int unsigned load_len;
   logic [7:0]  window [MaxPatternLen];
   int unsigned window_fill;
   logic [31:0] text_pos;
   logic [31:0] text_hits;

   function automatic logic [7:0] to_lower(input logic en, input logic [7:0] c);
      if (en && c >= 8'h41 && c <= 8'h5a) return c + 8'h20;
      return c;
   endfunction

   function automatic bit hit_ends_here(input int unsigned p);
      int unsigned n;
      n = pat_len[p];
      if (n == 0 || n > window_fill) return 0;
      for (int unsigned j = 0; j < n; j++) begin
         if (to_lower(fold_en, pat_mem[p][j]) != to_lower(fold_en, window[n - 1 - j]))
            return 0;
      end
      return 1;
   endfunction

   task automatic predict_word(input logic [1:0] act, input logic [7:0] b, input logic lst);
      match_word_t w;
      int first_new;
      first_new = match_queue.size();
      case (act)
         ActAppend: begin
            if (stored_pats < MaxPatterns && load_len < MaxPatternLen) begin
               pat_mem[stored_pats][load_len] = b;
               load_len++;
            end
         end
         ActClose: begin
            if (stored_pats < MaxPatterns && load_len != 0) begin
               pat_len[stored_pats] = load_len;
               stored_pats++;
            end
            load_len = 0;
         end
         ActText: begin
            for (int i = MaxPatternLen - 1; i > 0; i--) window[i] = window[i - 1];
            window[0] = b;
            if (window_fill < MaxPatternLen) window_fill++;
            for (int p = stored_pats; p > 0; p--) begin
               if (hit_ends_here(p - 1)) begin
                  w = '0;
                  w.number = p[5:0];
                  w.offset = text_pos - (pat_len[p - 1] - 1);
                  match_queue.push_back(w);
                  if (text_hits != 32'hffff_ffff) text_hits++;
               end
            end
            text_pos++;
            if (lst) begin
               w = '0;
               w.total = text_hits;
               w.summary = 1'b1;
               match_queue.push_back(w);
               for (int i = 0; i < MaxPatternLen; i++) window[i] = '0;
               window_fill = 0;
               text_pos = '0;
               text_hits = '0;
            end
         end
         default: ;
      endcase
      if (match_queue.size() > first_new) match_queue[match_queue.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      match_word_t e;
      match_word_t a;
      if (reset) begin
         fold_en = 1'b0;
         stored_pats = 0;
         load_len = 0;
         for (int i = 0; i < MaxPatterns; i++) pat_len[i] = 0;
         for (int i = 0; i < MaxPatternLen; i++) window[i] = '0;
         window_fill = 0;
         text_pos = '0;
         text_hits = '0;
         match_queue.delete();
         fail_count = 0;
         match_words_seen = 0;
         summary_words_seen = 0;
      end else begin
         if (csr_valid && csr_ready) fold_en = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            a.number  = rsp_tdata[5:0];
            a.offset  = rsp_tdata[37:6];
            a.total   = rsp_tdata[69:38];
            a.summary = rsp_tuser;
            a.last    = rsp_tlast;
            if (a.summary) summary_words_seen++;
            else match_words_seen++;
            if (match_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("[%0t] unexpected word: num=%0d off=%0d total=%0d summ=%0b last=%0b",
                           $realtime, a.number, a.offset, a.total, a.summary, a.last);
            end else begin
               e = match_queue.pop_front();
               if (e != a) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"[%0t] word mismatch: exp num=%0d off=%0d total=%0d summ=%0b ",
                               "last=%0b, got num=%0d off=%0d total=%0d summ=%0b last=%0b"},
                              $realtime, e.number, e.offset, e.total, e.summary, e.last,
                              a.number, a.offset, a.total, a.summary, a.last);
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_word(req_tuser, req_tdata, req_tlast);
      end
      pending_matches = match_queue.size();
   end
endmodule

// File: tb/tb_top.sv
// Top of the multi-pattern exact matcher testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
   import mpem_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [1:0]  req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_data;

   int  fail_count;
   int  pending_matches;
   int  match_words_seen;
   int  summary_words_seen;
   int  words_sent;
   int  texts_sent;
   int  fold_writes;
   bit  steady_send;
   bit  hold_request;
   int  cycle_num;

   multi_pattern_exact_matcher_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   mpem_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .req_tuser          (req_tuser),
      .req_tlast          (req_tlast),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .rsp_tuser          (rsp_tuser),
      .rsp_tlast          (rsp_tlast),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data),
      .fail_count         (fail_count),
      .pending_matches    (pending_matches),
      .match_words_seen   (match_words_seen),
      .summary_words_seen (summary_words_seen)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // receiver: random stalls, a periodic quiet window, long hold on request
   initial begin
      int hold_left;
      rsp_tready = 1'b0;
      cycle_num = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         cycle_num++;
         if (hold_request && hold_left == 0) begin
            hold_left = 400;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (cycle_num % 4000 < 700) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 28);
         end
      end
   end

   initial begin
      #(12 * 2_000_000);
      $display("Mismatches found");
      $finish;
   end

   task automatic send_word(input logic [1:0] act, input logic [7:0] b, input logic lst);
      while (!steady_send && $urandom_range(0, 99) < 28) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= act;
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      if (act == ActText && lst) texts_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_matches != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_fold(input logic v);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      fold_writes++;
   endtask

   task automatic load_pattern(input string s);
      for (int i = 0; i < s.len(); i++) send_word(ActAppend, s[i], 1'b0);
      send_word(ActClose, 8'h00, 1'b0);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(ActText, s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] pick_byte();
      string alpha;
      alpha = "abAB";
      if ($urandom_range(0, 99) < 80) return alpha[$urandom_range(0, 3)];
      return 8'($urandom_range(0, 255));
   endfunction

   initial begin
      int kind;
      int n;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = 1'b0;
      words_sent = 0;
      texts_sent = 0;
      fold_writes = 0;
      steady_send = 1'b0;
      hold_request = 1'b0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty close, stray last, unknown action, unclosed pattern
      send_word(ActClose, 8'h00, 1'b0);
      send_word(ActAppend, "a", 1'b1);
      send_word(ActAppend, "B", 1'b0);
      send_word(ActClose, 8'hff, 1'b1);
      send_word(2'd3, 8'hff, 1'b1);
      load_pattern("b");
      send_word(ActAppend, 8'h00, 1'b0);
      send_text("aBbA");
      send_word(ActClose, 8'h00, 1'b0);
      write_fold(1'b1);
      send_word(ActText, "a", 1'b0);
      send_word(ActText, "b", 1'b0);
      send_word(ActText, 8'h00, 1'b0);
      send_word(ActText, "B", 1'b1);
      send_word(ActText, 8'hff, 1'b1);
      // too-long pattern keeps first 32 bytes
      for (int i = 0; i < 34; i++) send_word(ActAppend, "A", 1'b0);
      send_word(ActClose, 8'h00, 1'b0);
      for (int i = 0; i < 33; i++) send_word(ActText, "a", i == 32);
      write_fold(1'b0);

      // random: well-formed patterns and texts, with noise
      while (words_sent < 270) begin
         steady_send = (words_sent >= 150 && words_sent < 210);
         if (words_sent > 240 && words_sent < 250 && !hold_request) hold_request = 1'b1;
         kind = $urandom_range(0, 99);
         if (kind < 20) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) send_word(ActAppend, pick_byte(), 1'b0);
            send_word(ActClose, 8'h00, 1'($urandom_range(0, 1)));
         end else if (kind < 27) begin
            send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
         end else if (kind < 30) begin
            write_fold(1'($urandom_range(0, 1)));
         end else begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) send_word(ActText, pick_byte(), i == n - 1);
         end
      end
      write_fold(1'b1);
      send_text("abAB");
      drain_results();

      $display("Sent %0d words in %0d texts with %0d fold_case writes;", words_sent,
               texts_sent, fold_writes);
      $display("checked %0d match words and %0d summary words.", match_words_seen,
               summary_words_seen);
      if (fail_count == 0 && pending_matches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

// File: files.f
sv/mpem_pkg.sv
sv/mpem_ram.sv
sv/mpem_datapath.sv
sv/mpem_ctrl.sv
sv/multi_pattern_exact_matcher_core.sv
tb/mpem_checker.sv
tb/tb_top.sv
